@@ rtl/core/ldfs_pkg.sv @@
// Shared types, constants and helpers for the LED digit frame serializer.
// Used by the interfaces, the front, the queue, the back and the top level.
package ldfs_pkg;

   localparam int DIGITS_DEFAULT = 8;
   localparam int MAX_RESULTS    = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam int SEG_W   = 8;
   localparam int LIGHT_W = 10;
   localparam int LEVEL_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_LEVEL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_BRIGHTNESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_DIGITS   = 2'd2;

   // Driver command bytes.
   localparam logic [7:0] CMD_DATA    = 8'h40;
   localparam logic [7:0] CMD_ADDRESS = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY = 8'h88;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd7;

   // One classified digit, handed from the front to the back.
   typedef struct packed {
      logic [SEG_W-1:0]   seg;
      logic               is_first;
      logic               is_final;
      logic [LEVEL_W-1:0] level;
   } desc_type;

   // Segment remap for a digit mounted upside down: a<->d, b<->e, c<->f.
   function automatic logic [SEG_W-1:0] rotate_segments(input logic [SEG_W-1:0] s);
      rotate_segments = {s[7:6], s[2], s[1], s[0], s[5], s[4], s[3]};
   endfunction

endpackage

@@ rtl/core/ldfs_ifs.sv @@
// Valid/ready channel interfaces for the request and result sides.
// Depends on ldfs_pkg for field widths.
interface ldfs_req_if;
   logic                        valid;
   logic                        ready;
   logic [ldfs_pkg::SEG_W-1:0]   segment_byte;
   logic [ldfs_pkg::LIGHT_W-1:0] ambient_light;

   modport source (output valid, output segment_byte, output ambient_light, input ready);
   modport sink (input valid, input segment_byte, input ambient_light, output ready);
endinterface

interface ldfs_rsp_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic window_start;
   logic frame_end;
   logic last;

   modport source (output valid, output data_bit, output window_start, output frame_end,
                   output last, input ready);
   modport sink (input valid, input data_bit, input window_start, input frame_end,
                 input last, output ready);
endinterface

@@ rtl/core/ldfs_front.sv @@
// Front end: configuration registers, request acceptance and digit classification.
// Depends on ldfs_pkg and ldfs_req_if.
module ldfs_front #(
   parameter int DIGITS = ldfs_pkg::DIGITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   ldfs_req_if.sink                          req_ch,
   input  logic                              csr_we,
   input  logic [ldfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ldfs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ldfs_pkg::desc_type                push_desc,
   output logic                              push_valid,
   input  logic                              push_ready
);

   localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [ldfs_pkg::LEVEL_W-1:0] manual_level_ff, manual_level_in;
   logic                         auto_ff, auto_in;
   logic                         rotate_ff, rotate_in;
   logic                         accept;
   logic                         is_final;
   logic [ldfs_pkg::LEVEL_W-1:0] level;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;
   assign is_final     = (pos_ff == LAST_POS);

   // In auto mode the level is 7 minus the top three light bits.
   assign level = auto_ff ? ~req_ch.ambient_light[ldfs_pkg::LIGHT_W-1 -: ldfs_pkg::LEVEL_W]
                          : manual_level_ff;

   always_comb begin
      push_desc.seg      = rotate_ff ? ldfs_pkg::rotate_segments(req_ch.segment_byte)
                                     : req_ch.segment_byte;
      push_desc.is_first = (pos_ff == '0);
      push_desc.is_final = is_final;
      push_desc.level    = level;
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = is_final ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      manual_level_in = manual_level_ff;
      auto_in         = auto_ff;
      rotate_in       = rotate_ff;
      if (csr_we) begin
         case (csr_index)
            ldfs_pkg::CSR_MANUAL_LEVEL:    manual_level_in = csr_wdata;
            ldfs_pkg::CSR_AUTO_BRIGHTNESS: auto_in = csr_wdata[0];
            ldfs_pkg::CSR_ROTATE_DIGITS:   rotate_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         manual_level_ff <= ldfs_pkg::LEVEL_RESET;
         auto_ff         <= 1'b0;
         rotate_ff       <= 1'b0;
      end else begin
         pos_ff          <= pos_in;
         manual_level_ff <= manual_level_in;
         auto_ff         <= auto_in;
         rotate_ff       <= rotate_in;
      end
   end

endmodule

@@ rtl/core/ldfs_queue.sv @@
// Two-entry descriptor queue between the front and the back.
// Depends on ldfs_pkg for the descriptor type and depth.
module ldfs_queue (
   input  logic               clock,
   input  logic               reset,
   input  ldfs_pkg::desc_type push_desc,
   input  logic               push_valid,
   output logic               push_ready,
   output ldfs_pkg::desc_type pop_desc,
   output logic               pop_valid,
   input  logic               pop_ready
);

   localparam int PTR_W = (ldfs_pkg::QUEUE_DEPTH > 1) ? $clog2(ldfs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ldfs_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(ldfs_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ldfs_pkg::QUEUE_DEPTH - 1);

   ldfs_pkg::desc_type entry_ff [ldfs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/ldfs_back.sv @@
// Back end: walks the bytes of one digit descriptor and sends them bit by bit.
// Depends on ldfs_pkg and ldfs_rsp_if.
module ldfs_back (
   input  logic               clock,
   input  logic               reset,
   input  ldfs_pkg::desc_type pop_desc,
   input  logic               pop_valid,
   output logic               pop_ready,
   ldfs_rsp_if.source         rsp_ch
);

   localparam int CNT_W = $clog2(ldfs_pkg::MAX_RESULTS);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(ldfs_pkg::MAX_RESULTS - 1);

   typedef enum logic [2:0] {
      SLOT_DATA_CMD,
      SLOT_ADDR_CMD,
      SLOT_LOW,
      SLOT_HIGH,
      SLOT_BRIGHT
   } slot_type;

   ldfs_pkg::desc_type desc_ff, desc_in;
   slot_type           slot_ff, slot_in, slot_next;
   logic [2:0]         bit_ff, bit_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_data_ff, out_data_in;
   logic               out_window_ff, out_window_in;
   logic               out_frame_end_ff, out_frame_end_in;
   logic               out_last_ff, out_last_in;
   logic [7:0]         cur_byte;
   logic               opens;
   logic               end_slot;
   logic               is_last;
   logic               advance;
   logic               load;

   always_comb begin
      case (slot_ff)
         SLOT_DATA_CMD: cur_byte = ldfs_pkg::CMD_DATA;
         SLOT_ADDR_CMD: cur_byte = ldfs_pkg::CMD_ADDRESS;
         SLOT_LOW:      cur_byte = {4'h0, desc_ff.seg[3:0] & ldfs_pkg::NIBBLE_MASK};
         SLOT_HIGH:     cur_byte = {4'h0, desc_ff.seg[7:4] & ldfs_pkg::NIBBLE_MASK};
         SLOT_BRIGHT:   cur_byte = ldfs_pkg::CMD_DISPLAY | {5'd0, desc_ff.level};
         default:       cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (slot_ff)
         SLOT_DATA_CMD: slot_next = SLOT_ADDR_CMD;
         SLOT_ADDR_CMD: slot_next = SLOT_LOW;
         SLOT_LOW:      slot_next = SLOT_HIGH;
         SLOT_HIGH:     slot_next = SLOT_BRIGHT;
         default:       slot_next = SLOT_BRIGHT;
      endcase
   end

   assign opens    = (slot_ff inside {SLOT_DATA_CMD, SLOT_ADDR_CMD, SLOT_BRIGHT});
   assign end_slot = desc_ff.is_final ? (slot_ff == SLOT_BRIGHT) : (slot_ff == SLOT_HIGH);
   // The result count is capped, which only cuts short a one-digit frame.
   assign is_last  = (end_slot && bit_ff == 3'd7) || (count_ff == LAST_COUNT);
   assign advance  = busy_ff && (!out_valid_ff || rsp_ch.ready);
   assign pop_ready = !busy_ff || (advance && is_last);
   assign load     = pop_ready && pop_valid;

   always_comb begin
      desc_in          = desc_ff;
      slot_in          = slot_ff;
      bit_in           = bit_ff;
      count_in         = count_ff;
      busy_in          = busy_ff;
      out_valid_in     = out_valid_ff && !rsp_ch.ready;
      out_data_in      = out_data_ff;
      out_window_in    = out_window_ff;
      out_frame_end_in = out_frame_end_ff;
      out_last_in      = out_last_ff;
      if (advance) begin
         out_valid_in     = 1'b1;
         out_data_in      = cur_byte[bit_ff];
         out_window_in    = opens && (bit_ff == 3'd0);
         out_frame_end_in = (slot_ff == SLOT_BRIGHT) && (bit_ff == 3'd7);
         out_last_in      = is_last;
         bit_in           = bit_ff + 3'd1;
         count_in         = count_ff + CNT_W'(1);
         if (bit_ff == 3'd7) begin
            slot_in = slot_next;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         desc_in  = pop_desc;
         slot_in  = pop_desc.is_first ? SLOT_DATA_CMD : SLOT_LOW;
         bit_in   = 3'd0;
         count_in = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff          <= SLOT_DATA_CMD;
         bit_ff           <= 3'd0;
         count_ff         <= '0;
         busy_ff          <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         slot_ff          <= slot_in;
         bit_ff           <= bit_in;
         count_ff         <= count_in;
         busy_ff          <= busy_in;
         out_valid_ff     <= out_valid_in;
      end
      desc_ff          <= desc_in;
      out_data_ff      <= out_data_in;
      out_window_ff    <= out_window_in;
      out_frame_end_ff <= out_frame_end_in;
      out_last_ff      <= out_last_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.data_bit     = out_data_ff;
   assign rsp_ch.window_start = out_window_ff;
   assign rsp_ch.frame_end    = out_frame_end_ff;
   assign rsp_ch.last         = out_last_ff;

   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_frame_end_ff |-> out_last_ff)
      else $error("frame end bit is not the last bit of its request");

   a_window_not_frame_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_window_ff |-> !out_frame_end_ff)
      else $error("window start and frame end on the same bit");

   a_busy_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !is_last |=> busy_ff)
      else $error("serializer went idle in the middle of a request");

   a_no_pop_midway: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !(advance && is_last) |-> !pop_ready)
      else $error("descriptor taken while the current one is unfinished");

endmodule

@@ rtl/core/led_digit_frame_serializer.sv @@
// Top level of the LED digit frame serializer: front, descriptor queue and back.
// Depends on ldfs_pkg, ldfs_req_if, ldfs_rsp_if, ldfs_front, ldfs_queue, ldfs_back.
//
// Usage: each request on req_ch carries the segment byte of one digit (and
// the ambient light reading, used on the frame's last digit in auto mode).
// DIGITS requests make one frame. Each request expands into serial bits on
// rsp_ch, one response per bit, least significant bit first: 32 bits for
// digit 0 (data and address commands plus two nibble bytes), 24 for the
// last digit (two nibble bytes plus the brightness command), 16 for others.
// A one-digit frame is cut at 32 bits. The last response of a request has
// last set.
// Throughput: one response per cycle while rsp_ch is ready, a rate set by
// the one-bit output register. When the serializer is idle, an accepted
// request passes through the queue entry, the back's descriptor register
// and the output register before its first bit is presented.
// A two-entry queue lets requests be accepted while earlier ones are still
// being sent. When rsp_ch stalls, the current bit holds and the queue
// fills, after which req_ch.ready drops.
// Reset (synchronous) returns to the start of a frame, empties the queue
// and sets manual level 7, manual mode and no rotation.
module led_digit_frame_serializer #(
   parameter int DIGITS = ldfs_pkg::DIGITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   ldfs_req_if.sink                         req_ch,
   ldfs_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [ldfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ldfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ldfs_pkg::desc_type push_desc;
   ldfs_pkg::desc_type pop_desc;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   ldfs_front #(
      .DIGITS(DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ldfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_desc  (push_desc),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_desc   (pop_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   ldfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_desc  (pop_desc),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ dv/ldfs_frame_checker.sv @@
// Checker for the LED digit frame serializer: predicts the serial bits of each request and
// compares them with the response channel. Depends on ldfs_pkg for widths, command bytes and
// register indexes; watches the configuration port to keep its own copy of the registers.
module ldfs_frame_checker #(
   parameter int DIGITS = ldfs_pkg::DIGITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ldfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ldfs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [ldfs_pkg::SEG_W-1:0]      req_segment_byte,
   input  logic [ldfs_pkg::LIGHT_W-1:0]    req_ambient_light,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_data_bit,
   input  logic                            rsp_window_start,
   input  logic                            rsp_frame_end,
   input  logic                            rsp_last,
   output int                              mismatches,
   output int                              bits_pending
);

   typedef struct packed {
      logic data_bit;
      logic window_start;
      logic frame_end;
      logic last;
   } serial_bit_type;

   serial_bit_type                 expected_bits[$];
   logic [ldfs_pkg::LEVEL_W-1:0]   manual_level;
   logic                           auto_mode;
   logic                           rotate_mode;
   int                             digit_index;
   int                             mismatch_count = 0;

   assign mismatches = mismatch_count;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Expands one digit request into the serial bits it should produce.
   task automatic expand_digit(input logic [ldfs_pkg::SEG_W-1:0] seg_in,
                               input logic [ldfs_pkg::LIGHT_W-1:0] light);
      serial_bit_type               staged[ldfs_pkg::MAX_RESULTS];
      logic [7:0]                   octets[5];
      logic                         octet_opens[5];
      logic                         octet_closes[5];
      logic [ldfs_pkg::SEG_W-1:0]   seg;
      logic [ldfs_pkg::LEVEL_W-1:0] level;
      int                           noctets;
      int                           count;
      noctets = 0;
      count = 0;
      // Upside-down mounting swaps segments a/d, b/e and c/f.
      seg = rotate_mode ? {seg_in[7:6], seg_in[2:0], seg_in[5:3]} : seg_in;
      if (digit_index == 0) begin
         octets[noctets] = ldfs_pkg::CMD_DATA;
         octet_opens[noctets] = 1'b1;
         octet_closes[noctets] = 1'b0;
         noctets++;
         octets[noctets] = ldfs_pkg::CMD_ADDRESS;
         octet_opens[noctets] = 1'b1;
         octet_closes[noctets] = 1'b0;
         noctets++;
      end
      octets[noctets] = {4'h0, seg[3:0]};
      octet_opens[noctets] = 1'b0;
      octet_closes[noctets] = 1'b0;
      noctets++;
      octets[noctets] = {4'h0, seg[7:4]};
      octet_opens[noctets] = 1'b0;
      octet_closes[noctets] = 1'b0;
      noctets++;
      if (digit_index + 1 >= DIGITS) begin
         level = auto_mode ? 3'd7 - light[ldfs_pkg::LIGHT_W-1:ldfs_pkg::LIGHT_W-3]
                           : manual_level;
         octets[noctets] = ldfs_pkg::CMD_DISPLAY | {5'b0, level};
         octet_opens[noctets] = 1'b1;
         octet_closes[noctets] = 1'b1;
         noctets++;
         digit_index = 0;
      end else begin
         digit_index++;
      end
      // A frame too long for one request is cut at the result limit.
      for (int i = 0; i < noctets; i++) begin
         for (int b = 0; b < 8; b++) begin
            if (count < ldfs_pkg::MAX_RESULTS) begin
               staged[count].data_bit = octets[i][b];
               staged[count].window_start = octet_opens[i] && (b == 0);
               staged[count].frame_end = octet_closes[i] && (b == 7);
               staged[count].last = 1'b0;
               count++;
            end
         end
      end
      staged[count-1].last = 1'b1;
      for (int i = 0; i < count; i++) begin
         expected_bits.push_back(staged[i]);
      end
   endtask

   always @(posedge clock) begin : monitor
      serial_bit_type want;
      if (reset) begin
         expected_bits.delete();
         digit_index = 0;
         manual_level = ldfs_pkg::LEVEL_RESET;
         auto_mode = 1'b0;
         rotate_mode = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ldfs_pkg::CSR_MANUAL_LEVEL:    manual_level = csr_wdata;
               ldfs_pkg::CSR_AUTO_BRIGHTNESS: auto_mode = csr_wdata[0];
               ldfs_pkg::CSR_ROTATE_DIGITS:   rotate_mode = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bits.size() == 0) begin
               report_mismatch("response bit with nothing expected");
            end else begin
               want = expected_bits.pop_front();
               if (rsp_data_bit !== want.data_bit)
                  report_mismatch($sformatf("data_bit %b, expected %b",
                                            rsp_data_bit, want.data_bit));
               if (rsp_window_start !== want.window_start)
                  report_mismatch($sformatf("window_start %b, expected %b",
                                            rsp_window_start, want.window_start));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, expected %b",
                                            rsp_frame_end, want.frame_end));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
            end
         end
         if (req_valid && req_ready) begin
            expand_digit(req_segment_byte, req_ambient_light);
         end
      end
      bits_pending <= expected_bits.size();
   end

endmodule

@@ dv/led_digit_frame_serializer_tb.sv @@
// Testbench top for the LED digit frame serializer: clock, reset, digit requests, response
// stalls and configuration phases. Depends on ldfs_pkg, the channel interfaces, the block and
// ldfs_frame_checker, which does all prediction and comparison.
module led_digit_frame_serializer_tb;

   localparam int DIGITS       = ldfs_pkg::DIGITS_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [ldfs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we;
   logic [ldfs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ldfs_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                              cycle_count = 0;
   int                              mismatches;
   int                              bits_pending;
   int                              burst_left = 0;
   int                              gap_max = 3;

   ldfs_req_if req_ch();
   ldfs_rsp_if rsp_ch();

   always #1 clock = ~clock;

   led_digit_frame_serializer #(.DIGITS(DIGITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ldfs_frame_checker #(.DIGITS(DIGITS)) frame_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_segment_byte  (req_ch.segment_byte),
      .req_ambient_light (req_ch.ambient_light),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_data_bit      (rsp_ch.data_bit),
      .rsp_window_start  (rsp_ch.window_start),
      .rsp_frame_end     (rsp_ch.frame_end),
      .rsp_last          (rsp_ch.last),
      .mismatches        (mismatches),
      .bits_pending      (bits_pending)
   );

   // The receiver cycles through stretches of full rate, light stalls, a fixed stall
   // pattern and heavy random stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count >> 9) % 4)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ((cycle_count % 5) != 2);
         default: rsp_ch.ready <= 1'($urandom_range(0, 1));
      endcase
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Leaves csr_we high; the caller lowers it after the last write.
   task automatic csr_write(input logic [ldfs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ldfs_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [ldfs_pkg::LEVEL_W-1:0] level, input logic auto_on,
                                 input logic rotate_on, input logic poke_unused);
      csr_write(ldfs_pkg::CSR_MANUAL_LEVEL, level);
      csr_write(ldfs_pkg::CSR_AUTO_BRIGHTNESS, {2'b0, auto_on});
      csr_write(ldfs_pkg::CSR_ROTATE_DIGITS, {2'b0, rotate_on});
      // A write to an unused index must leave every register alone.
      if (poke_unused) csr_write(CSR_UNUSED, 3'($urandom_range(0, 7)));
      csr_we <= 1'b0;
   endtask

   // Sends one digit request; the sender works in bursts separated by random gaps.
   task automatic send_digit(input logic [ldfs_pkg::SEG_W-1:0] seg,
                             input logic [ldfs_pkg::LIGHT_W-1:0] light);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.segment_byte <= seg;
      req_ch.ambient_light <= light;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 10);
      end
   endtask

   // Holds off the sender until every predicted bit has come out and the block is quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (bits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [ldfs_pkg::SEG_W-1:0]   seg;
      logic [ldfs_pkg::LIGHT_W-1:0] light;
      logic [ldfs_pkg::SEG_W-1:0]   mixed_segs[8];
      int                           phase_items;
      req_ch.valid <= 1'b0;
      req_ch.segment_byte <= '0;
      req_ch.ambient_light <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Manual mode at the dimmest level: walking ones then walking zeros, so every
      // segment bit is seen alone; the light reading alternates and must be ignored.
      apply_settings(3'd0, 1'b0, 1'b0, 1'b1);
      for (int i = 0; i < 8; i++) begin
         seg = 8'h01 << i;
         send_digit(seg, (i % 2) ? 10'h3FF : 10'h000);
      end
      for (int i = 0; i < 8; i++) begin
         seg = ~(8'h01 << i);
         send_digit(seg, (i % 2) ? 10'h000 : 10'h3FF);
      end
      settle();

      // Auto brightness with rotation; the brightest light gives the lowest level.
      apply_settings(3'd7, 1'b1, 1'b1, 1'b0);
      mixed_segs = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h38, 8'h07, 8'hC0, 8'h3F};
      for (int i = 0; i < 8; i++) begin
         send_digit(mixed_segs[i], 10'h3FF);
      end
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(3'd7, 1'b0, 1'b0, 1'b0);
            1: apply_settings(3'd0, 1'b1, 1'b1, 1'b0);
            default: apply_settings(3'($urandom_range(0, 7)), 1'(phase % 2),
                                    1'((phase / 2) % 2), phase == 5);
         endcase
         gap_max = (phase == 3) ? 0 : ((phase == 4) ? 12 : 5);
         phase_items = $urandom_range(30, 38);
         for (int n = 0; n < phase_items; n++) begin
            case ($urandom_range(0, 3))
               0: light = '0;
               1: light = '1;
               default: light = 10'($urandom_range(0, 1023));
            endcase
            send_digit(8'($urandom_range(0, 255)), light);
            if ($urandom_range(0, 49) == 0) settle();
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/ldfs_pkg.sv
rtl/core/ldfs_ifs.sv
rtl/core/ldfs_front.sv
rtl/core/ldfs_queue.sv
rtl/core/ldfs_back.sv
rtl/core/led_digit_frame_serializer.sv
dv/ldfs_frame_checker.sv
dv/led_digit_frame_serializer_tb.sv
